### hw/rtl/vpi_pkg.sv
// ----------------------------------------------------------------------------
// vpi_pkg
// Types, constants, microcode store and helpers for the damped Verlet point
// mass integrator.
// ----------------------------------------------------------------------------
package vpi_pkg;

  localparam int unsigned PC_W  = 5;
  localparam int unsigned ACC_W = 52;

  localparam logic [1:0] KIND_PLACE = 2'd0;
  localparam logic [1:0] KIND_FORCE = 2'd1;
  localparam logic [1:0] KIND_ACCEL = 2'd2;
  localparam logic [1:0] KIND_STEP  = 2'd3;

  localparam logic [1:0] CFG_FRICTION     = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP    = 2'd1;
  localparam logic [1:0] CFG_INVERSE_MASS = 2'd2;

  localparam logic [16:0] FRICTION_RST     = 17'd0;
  localparam logic [15:0] TIME_STEP_RST    = 16'd655;
  localparam logic [31:0] INVERSE_MASS_RST = 32'd65536;
  localparam logic [16:0] Q_ONE            = 17'd65536;
  localparam logic [17:0] Q_TWO            = 18'd131072;

  // program labels
  localparam logic [PC_W-1:0] PC_STEP       = 5'd0;
  localparam logic [PC_W-1:0] PC_STEP_LOOP  = 5'd2;
  localparam logic [PC_W-1:0] PC_FORCE      = 5'd10;
  localparam logic [PC_W-1:0] PC_ACCEL      = 5'd15;
  localparam logic [PC_W-1:0] PC_PLACE      = 5'd19;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } out_t;

  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    OPA_POS,
    OPA_PREV,
    OPA_ACC,
    OPA_VAL,
    OPA_DT
  } opa_t;

  typedef enum logic [2:0] {
    OPB_C1,
    OPB_C2,
    OPB_DT2,
    OPB_DT2X,
    OPB_INVM,
    OPB_DT
  } opb_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    SRC_PROD,
    SRC_VAL,
    SRC_ACC,
    SRC_PVEL
  } src_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_DT2,
    WB_POS,
    WB_VEL,
    WB_ACC,
    WB_PLACE
  } wb_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_AX0,
    JMP_END
  } jmp_t;

  typedef struct packed {
    opa_t             a_sel;
    opb_t             b_sel;
    acc_op_t          acc_op;
    src_t             acc_src;
    logic             acc_shr;
    logic             sat_base;
    wb_t              wb;
    logic             ax_flip;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   ax;
  } ctl_t;

  localparam uword_t UW_NOP = '{
    a_sel: OPA_POS, b_sel: OPB_C1, acc_op: ACC_HOLD, acc_src: SRC_PROD,
    acc_shr: 1'b0, sat_base: 1'b0, wb: WB_NONE, ax_flip: 1'b0,
    jmp: JMP_NEXT, target: '0
  };

  function automatic logic [PC_W-1:0] entry(input logic [1:0] kind);
    logic [PC_W-1:0] pc;
    unique case (kind)
      KIND_PLACE: pc = PC_PLACE;
      KIND_FORCE: pc = PC_FORCE;
      KIND_ACCEL: pc = PC_ACCEL;
      KIND_STEP:  pc = PC_STEP;
      default:    pc = PC_STEP;
    endcase
    return pc;
  endfunction

  // microcode store, one control word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UW_NOP;
    unique case (pc)
      // step: dt squared, then per axis position and velocity
      PC_STEP: begin
        w.a_sel = OPA_DT;
        w.b_sel = OPB_DT;
      end
      PC_STEP + 5'd1: begin
        w.wb = WB_DT2;
      end
      PC_STEP_LOOP: begin
        w.a_sel = OPA_POS;
        w.b_sel = OPB_C1;
      end
      PC_STEP_LOOP + 5'd1: begin
        w.a_sel  = OPA_PREV;
        w.b_sel  = OPB_C2;
        w.acc_op = ACC_LOAD;
      end
      PC_STEP_LOOP + 5'd2: begin
        w.a_sel  = OPA_ACC;
        w.b_sel  = OPB_DT2;
        w.acc_op = ACC_SUB;
      end
      PC_STEP_LOOP + 5'd3: begin
        w.a_sel   = OPA_ACC;
        w.b_sel   = OPB_DT2X;
        w.acc_op  = ACC_ADD;
        w.acc_shr = 1'b1;
      end
      PC_STEP_LOOP + 5'd4: begin
        w.wb      = WB_POS;
        w.acc_op  = ACC_LOAD;
        w.acc_shr = 1'b1;
      end
      PC_STEP_LOOP + 5'd5: begin
        w.acc_op  = ACC_ADD;
        w.acc_src = SRC_PVEL;
      end
      PC_STEP_LOOP + 5'd6: begin
        w.wb      = WB_VEL;
        w.ax_flip = 1'b1;
        w.jmp     = JMP_AX0;
        w.target  = PC_STEP_LOOP;
      end
      PC_STEP_LOOP + 5'd7: begin
        w.jmp = JMP_END;
      end
      // add force scaled by inverse mass
      PC_FORCE: begin
        w.a_sel = OPA_VAL;
        w.b_sel = OPB_INVM;
      end
      PC_FORCE + 5'd1: begin
        w.acc_op  = ACC_LOAD;
        w.acc_shr = 1'b1;
      end
      PC_FORCE + 5'd2: begin
        w.acc_op   = ACC_ADD;
        w.acc_src  = SRC_ACC;
        w.sat_base = 1'b1;
      end
      PC_FORCE + 5'd3: begin
        w.wb      = WB_ACC;
        w.ax_flip = 1'b1;
        w.jmp     = JMP_AX0;
        w.target  = PC_FORCE;
      end
      PC_FORCE + 5'd4: begin
        w.jmp = JMP_END;
      end
      // add acceleration
      PC_ACCEL: begin
        w.acc_op  = ACC_LOAD;
        w.acc_src = SRC_VAL;
      end
      PC_ACCEL + 5'd1: begin
        w.acc_op  = ACC_ADD;
        w.acc_src = SRC_ACC;
      end
      PC_ACCEL + 5'd2: begin
        w.wb      = WB_ACC;
        w.ax_flip = 1'b1;
        w.jmp     = JMP_AX0;
        w.target  = PC_ACCEL;
      end
      PC_ACCEL + 5'd3: begin
        w.jmp = JMP_END;
      end
      // place
      PC_PLACE: begin
        w.wb = WB_PLACE;
      end
      PC_PLACE + 5'd1: begin
        w.jmp = JMP_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### hw/rtl/vpi_seq.sv
// ----------------------------------------------------------------------------
// vpi_seq
// Microcode sequencer: step counter, axis flag and conditional jumps.
// ----------------------------------------------------------------------------
module vpi_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      kind,
  input  logic            out_free,
  output vpi_pkg::ctl_t   ctl,
  output logic            busy,
  output logic            done
);

  vpi_pkg::seq_state_t         state_r, state_nxt;
  logic [vpi_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic                        ax_r, ax_nxt;
  vpi_pkg::uword_t             uw;

  assign uw = vpi_pkg::ucode(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpi_pkg::SEQ_IDLE;
      pc_r    <= '0;
      ax_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ax_r    <= ax_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ax_nxt    = ax_r;
    unique case (state_r)
      vpi_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = vpi_pkg::SEQ_RUN;
          pc_nxt    = vpi_pkg::entry(kind);
          ax_nxt    = 1'b0;
        end
      end
      vpi_pkg::SEQ_RUN: begin
        if (uw.ax_flip) begin
          ax_nxt = ~ax_r;
        end
        case (uw.jmp)
          vpi_pkg::JMP_NEXT: pc_nxt = pc_r + vpi_pkg::PC_W'(1);
          vpi_pkg::JMP_AX0:  pc_nxt = ax_r ? pc_r + vpi_pkg::PC_W'(1) : uw.target;
          vpi_pkg::JMP_END: begin
            if (out_free) begin
              state_nxt = vpi_pkg::SEQ_IDLE;
            end
          end
          default: pc_nxt = pc_r;
        endcase
      end
      default: state_nxt = vpi_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    done   = 1'b0;
    ctl.uw = vpi_pkg::UW_NOP;
    ctl.ax = ax_r;
    unique case (state_r)
      vpi_pkg::SEQ_IDLE: begin
        busy = 1'b0;
      end
      vpi_pkg::SEQ_RUN: begin
        busy   = 1'b1;
        ctl.uw = uw;
        done   = (uw.jmp == vpi_pkg::JMP_END) && out_free;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### hw/rtl/vpi_datapath.sv
// ----------------------------------------------------------------------------
// vpi_datapath
// Shared multiplier, wide accumulator and integrator state, driven by one
// control word per cycle.
// ----------------------------------------------------------------------------
module vpi_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  vpi_pkg::ctl_t       ctl,
  input  logic                load,
  input  vpi_pkg::in_t        item,
  input  logic [16:0]         friction,
  input  logic [15:0]         time_step,
  input  logic [31:0]         inverse_mass,
  output vpi_pkg::out_t       res
);

  localparam int unsigned AW = vpi_pkg::ACC_W;

  logic signed [31:0]    pos_r  [2];
  logic signed [31:0]    prev_r [2];
  logic signed [31:0]    vel_r  [2];
  logic signed [31:0]    pvel_r [2];
  logic signed [31:0]    acc_r  [2];
  logic signed [31:0]    val_r  [2];
  logic        [31:0]    dt2_r;
  logic signed [63:0]    prod_r;
  logic signed [AW-1:0]  accum_r, accum_nxt;

  logic        [16:0]    fcl;
  logic        [17:0]    c1;
  logic        [16:0]    c2;
  logic signed [31:0]    sa;
  logic signed [32:0]    opa, opb;
  logic signed [65:0]    mul_full;
  logic signed [63:0]    prod_sh;
  logic signed [31:0]    ss;
  logic signed [31:0]    sat_acc;
  logic signed [AW-1:0]  addend, base;
  logic signed [AW-1:0]  accum_sh;
  logic signed [31:0]    wv;

  // friction above one acts as one
  assign fcl = (friction > vpi_pkg::Q_ONE) ? vpi_pkg::Q_ONE : friction;
  assign c1  = vpi_pkg::Q_TWO - {1'b0, fcl};
  assign c2  = vpi_pkg::Q_ONE - fcl;

  always_comb begin
    case (ctl.uw.a_sel)
      vpi_pkg::OPA_POS:  sa = pos_r[ctl.ax];
      vpi_pkg::OPA_PREV: sa = prev_r[ctl.ax];
      vpi_pkg::OPA_ACC:  sa = acc_r[ctl.ax];
      vpi_pkg::OPA_VAL:  sa = val_r[ctl.ax];
      default:           sa = '0;
    endcase
    if (ctl.uw.a_sel == vpi_pkg::OPA_DT) begin
      opa = {17'd0, time_step};
    end else begin
      opa = {sa[31], sa};
    end
  end

  always_comb begin
    case (ctl.uw.b_sel)
      vpi_pkg::OPB_C1:   opb = {15'd0, c1};
      vpi_pkg::OPB_C2:   opb = {16'd0, c2};
      vpi_pkg::OPB_DT2:  opb = {1'b0, dt2_r};
      vpi_pkg::OPB_DT2X: opb = {16'd0, time_step, 1'b0};
      vpi_pkg::OPB_INVM: opb = {1'b0, inverse_mass};
      vpi_pkg::OPB_DT:   opb = {17'd0, time_step};
      default:           opb = '0;
    endcase
  end

  assign mul_full = opa * opb;
  assign prod_sh  = prod_r >>> 16;
  assign accum_sh = accum_r >>> 16;
  assign sat_acc  = vpi_pkg::sat32(accum_r);

  always_comb begin
    case (ctl.uw.acc_src)
      vpi_pkg::SRC_VAL:  ss = val_r[ctl.ax];
      vpi_pkg::SRC_ACC:  ss = acc_r[ctl.ax];
      vpi_pkg::SRC_PVEL: ss = pvel_r[ctl.ax];
      default:           ss = '0;
    endcase
    if (ctl.uw.acc_src == vpi_pkg::SRC_PROD) begin
      addend = ctl.uw.acc_shr ? prod_sh[AW-1:0] : prod_r[AW-1:0];
    end else begin
      addend = {{(AW-32){ss[31]}}, ss};
    end
    if (ctl.uw.sat_base) begin
      base = {{(AW-32){sat_acc[31]}}, sat_acc};
    end else begin
      base = accum_r;
    end
    case (ctl.uw.acc_op)
      vpi_pkg::ACC_LOAD: accum_nxt = addend;
      vpi_pkg::ACC_ADD:  accum_nxt = base + addend;
      vpi_pkg::ACC_SUB:  accum_nxt = base - addend;
      default:           accum_nxt = accum_r;
    endcase
  end

  assign wv = (ctl.uw.wb == vpi_pkg::WB_POS) ? vpi_pkg::sat32(accum_sh)
                                             : sat_acc;

  always_ff @(posedge clk) begin
    prod_r  <= mul_full[63:0];
    accum_r <= accum_nxt;
    if (load) begin
      val_r[0] <= item.value_x;
      val_r[1] <= item.value_y;
    end
    if (ctl.uw.wb == vpi_pkg::WB_DT2) begin
      dt2_r <= prod_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        pos_r[i]  <= '0;
        prev_r[i] <= '0;
        vel_r[i]  <= '0;
        pvel_r[i] <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      unique case (ctl.uw.wb)
        vpi_pkg::WB_POS: begin
          prev_r[ctl.ax] <= pos_r[ctl.ax];
          pos_r[ctl.ax]  <= wv;
        end
        vpi_pkg::WB_VEL: begin
          pvel_r[ctl.ax] <= vel_r[ctl.ax];
          vel_r[ctl.ax]  <= wv;
          acc_r[ctl.ax]  <= '0;
        end
        vpi_pkg::WB_ACC: begin
          acc_r[ctl.ax] <= wv;
        end
        vpi_pkg::WB_PLACE: begin
          for (int i = 0; i < 2; i++) begin
            pos_r[i]  <= val_r[i];
            prev_r[i] <= val_r[i];
            vel_r[i]  <= '0;
            pvel_r[i] <= '0;
            acc_r[i]  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.pos_x  = pos_r[0];
  assign res.pos_y  = pos_r[1];
  assign res.prev_x = prev_r[0];
  assign res.prev_y = prev_r[1];
  assign res.vel_x  = vel_r[0];
  assign res.vel_y  = vel_r[1];
  assign res.acc_x  = acc_r[0];
  assign res.acc_y  = acc_r[1];

endmodule

### hw/rtl/verlet_particle_integrator.sv
// ----------------------------------------------------------------------------
// verlet_particle_integrator
// Damped position Verlet integrator for one 2D point mass in Q16.16.
// ----------------------------------------------------------------------------
// One transaction is taken while the block is idle and runs as a short
// microprogram on a single shared 33x33 multiplier and a 52-bit
// accumulator, one control word per cycle, x axis then y axis. A place
// loads the state directly, an add-acceleration or add-force works per
// axis, and a step forms dt squared once, then position and velocity per
// axis, then the result word, which waits while an earlier result is
// still held. The result is held in an output register, so the next
// transaction is accepted while it waits to be taken. Configuration writes
// are always ready and are meant to happen only while the block is idle.
module verlet_particle_integrator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vpi_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output vpi_pkg::out_t   out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  logic [16:0]    friction_r;
  logic [15:0]    time_step_r;
  logic [31:0]    inv_mass_r;
  logic           out_valid_r, out_valid_nxt;
  vpi_pkg::out_t  out_data_r;
  vpi_pkg::out_t  res;
  vpi_pkg::ctl_t  ctl;
  logic           busy;
  logic           done;
  logic           in_fire;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid & ~busy;
  assign out_free  = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r  <= vpi_pkg::FRICTION_RST;
      time_step_r <= vpi_pkg::TIME_STEP_RST;
      inv_mass_r  <= vpi_pkg::INVERSE_MASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vpi_pkg::CFG_FRICTION:     friction_r  <= cfg_data[16:0];
        vpi_pkg::CFG_TIME_STEP:    time_step_r <= cfg_data[15:0];
        vpi_pkg::CFG_INVERSE_MASS: inv_mass_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vpi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .kind     (in_data.kind),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy),
    .done     (done)
  );

  vpi_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .load         (in_fire),
    .item         (in_data),
    .friction     (friction_r),
    .time_step    (time_step_r),
    .inverse_mass (inv_mass_r),
    .res          (res)
  );

  // result transaction register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
